/* rtl/rational_arith_reduce_macros.svh */
// Assertion macros shared by the rational reduction RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef RATIONAL_ARITH_REDUCE_MACROS_SVH
`define RATIONAL_ARITH_REDUCE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define RAR_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rar: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RAR_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rar: next-cycle check failed");

`else

`define RAR_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define RAR_ASSERT_NXT(lbl, ck, rn, ante, cons)

`endif

`endif

/* rtl/rar_pkg.sv */
package rar_pkg;

    // Operand width: numerators are WIDTH bits signed, denominators WIDTH-1 bits.
    localparam int WIDTH = 16;

    // Port field widths.
    localparam int FUNC_W    = 2;
    localparam int IN_NUM_W  = 16;
    localparam int IN_DEN_W  = 15;
    localparam int RES_NUM_W = 32;
    localparam int RES_DEN_W = 30;

    // Internal widths that follow from WIDTH.
    localparam int PROD_W = 2 * WIDTH;
    localparam int MAG_W  = 2 * WIDTH - 1;
    localparam int DEN_W  = 2 * WIDTH - 2;
    localparam int CNT_W  = $clog2(MAG_W);

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD = 2'd0,
        FN_SUB = 2'd1,
        FN_MUL = 2'd2,
        FN_DIV = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_SIGN,
        ST_ABS,
        ST_REDUCE,
        ST_OUT
    } top_state_t;

    typedef enum logic [2:0] {
        RD_IDLE,
        RD_TWOS,
        RD_GCD,
        RD_DIVN,
        RD_DIVD,
        RD_DONE
    } rd_state_t;

    // Request into the reduction unit.
    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] mag;
        logic [DEN_W-1:0] den;
    } rd_req_t;

    // Response from the reduction unit; mag and den hold until the next start.
    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] mag;
        logic [DEN_W-1:0] den;
    } rd_rsp_t;

endpackage

/* rtl/rar_mul.sv */
module rar_mul (
    input  logic                               clk,
    input  logic signed [rar_pkg::WIDTH-1:0]   x,
    input  logic signed [rar_pkg::WIDTH-1:0]   y,
    output logic signed [rar_pkg::PROD_W-1:0]  p_reg
);
    import rar_pkg::*;

    logic signed [PROD_W-1:0] prod;

    // Full signed product, registered before anyone uses it.
    assign prod = x * y;

    always_ff @(posedge clk)
    begin
        p_reg <= prod;
    end

endmodule

/* rtl/rar_reduce.sv */
`include "rational_arith_reduce_macros.svh"

module rar_reduce (
    input  logic              clk,
    input  logic              rst_n,
    input  rar_pkg::rd_req_t  req,
    output rar_pkg::rd_rsp_t  rsp
);
    import rar_pkg::*;

    rd_state_t          state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [MAG_W-1:0]   u_reg, u_next;
    logic [MAG_W-1:0]   v_reg, v_next;
    logic [MAG_W-1:0]   a_reg, a_next;
    logic [MAG_W-1:0]   b_reg, b_next;
    logic [MAG_W-1:0]   rem_reg, rem_next;

    logic [MAG_W:0]     shifted;
    logic [MAG_W:0]     sub_a;
    logic [MAG_W+1:0]   diff;
    logic               borrow;

    // The one subtractor: v - u in the GCD loop, partial remainder - u in division.
    assign shifted = {rem_reg, (state_reg == RD_DIVN) ? a_reg[MAG_W-1] : b_reg[MAG_W-1]};
    assign sub_a   = (state_reg == RD_GCD) ? {1'b0, v_reg} : shifted;
    assign diff    = {1'b0, sub_a} - {2'b00, u_reg};
    assign borrow  = diff[MAG_W+1];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            RD_IDLE:
            begin
                if (req.start)
                begin
                    u_next = req.mag;
                    v_next = MAG_W'(req.den);
                    a_next = req.mag;
                    b_next = MAG_W'(req.den);
                    if (req.mag == '0 || req.den == '0)
                        state_next = RD_DONE;
                    else
                        state_next = RD_TWOS;
                end
            end
            RD_TWOS:
            begin
                // Common powers of two come off both the GCD pair and the operands.
                if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                end
                else
                begin
                    state_next = RD_GCD;
                end
            end
            RD_GCD:
            begin
                if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (v_reg == '0)
                begin
                    rem_next   = '0;
                    cnt_next   = CNT_W'(MAG_W - 1);
                    state_next = RD_DIVN;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (borrow)
                begin
                    // Keep u the smaller of the two odd values.
                    u_next = v_reg;
                    v_next = u_reg;
                end
                else
                begin
                    v_next = diff[MAG_W-1:0];
                end
            end
            RD_DIVN, RD_DIVD:
            begin
                rem_next = borrow ? shifted[MAG_W-1:0] : diff[MAG_W-1:0];
                if (state_reg == RD_DIVN)
                    a_next = {a_reg[MAG_W-2:0], !borrow};
                else
                    b_next = {b_reg[MAG_W-2:0], !borrow};
                if (cnt_reg == '0)
                begin
                    rem_next   = '0;
                    cnt_next   = CNT_W'(MAG_W - 1);
                    state_next = (state_reg == RD_DIVN) ? RD_DIVD : RD_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            RD_DONE:
            begin
                state_next = RD_IDLE;
            end
            default:
            begin
                state_next = RD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg   <= u_next;
        v_reg   <= v_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = (state_reg == RD_DONE);
    assign rsp.mag  = a_reg;
    assign rsp.den  = b_reg[DEN_W-1:0];

    `RAR_ASSERT_IMP(a_gcd_u_nonzero, clk, rst_n, state_reg == RD_GCD, u_reg != '0)
    `RAR_ASSERT_IMP(a_div_u_odd, clk, rst_n,
        state_reg == RD_DIVN || state_reg == RD_DIVD, u_reg[0])
    `RAR_ASSERT_IMP(a_div_rem_bound, clk, rst_n,
        state_reg == RD_DIVN || state_reg == RD_DIVD, rem_reg < u_reg)
    `RAR_ASSERT_NXT(a_done_pulse, clk, rst_n, rsp.done, !rsp.done)

endmodule

/* rtl/rational_arith_reduce.sv */
// Channel | Dir | Handshake                  | Payload
// input   | in  | in_valid / in_stall        | func, a_num, a_den, b_num, b_den
// output  | out | out_valid / out_stall      | res_num, res_den, bad_den
//
// One item at a time. After a beat is taken, states MUL0 to MUL3 run the shared multiplier and
// states SIGN and ABS form the signed numerator and its magnitude. A zero numerator or
// denominator then skips reduction; otherwise the unit strips common twos, runs a binary GCD
// loop and divides both terms by the odd GCD part in two restoring divisions. Reset is
// asynchronous and active low and clears the sequencers and out_valid. in_stall is high until the
// result leaves the sequencer, so while out_stall holds one result the next one waits inside.
`include "rational_arith_reduce_macros.svh"

module rational_arith_reduce (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [rar_pkg::FUNC_W-1:0]            func,
    input  logic signed [rar_pkg::IN_NUM_W-1:0]   a_num,
    input  logic [rar_pkg::IN_DEN_W-1:0]          a_den,
    input  logic signed [rar_pkg::IN_NUM_W-1:0]   b_num,
    input  logic [rar_pkg::IN_DEN_W-1:0]          b_den,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [rar_pkg::RES_NUM_W-1:0]  res_num,
    output logic [rar_pkg::RES_DEN_W-1:0]         res_den,
    output logic                                  bad_den
);
    import rar_pkg::*;

    top_state_t               state_reg, state_next;
    func_t                    func_reg;
    logic signed [WIDTH-1:0]  an_reg, bn_reg;
    logic [WIDTH-2:0]         ad_reg, bd_reg;
    logic signed [WIDTH-1:0]  ad_s, bd_s;

    logic signed [WIDTH-1:0]  mul_x, mul_y;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] pa_reg, pb_reg, pc_reg;
    logic signed [PROD_W-1:0] n_reg, n_next;
    logic signed [PROD_W-1:0] d_reg, d_next;
    logic signed [PROD_W-1:0] n_abs;
    logic                     neg_reg, bad_reg;

    rd_req_t                  rd_req;
    rd_rsp_t                  rd_rsp;
    logic                     rd_start;

    logic                     in_fire;
    logic                     out_free;
    logic                     load_out;
    logic signed [MAG_W:0]    num_signed;

    logic                            out_valid_reg;
    logic signed [RES_NUM_W-1:0]     res_num_reg;
    logic [RES_DEN_W-1:0]            res_den_reg;
    logic                            bad_den_reg;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Denominators are unsigned, so a leading zero makes them valid signed operands.
    assign ad_s = $signed({1'b0, ad_reg});
    assign bd_s = $signed({1'b0, bd_reg});

    // Multiplier schedule: first product in MUL0, second in MUL1, ad*bd in MUL2.
    // Add and subtract use an*bd and bn*ad; divide uses an*bd and ad*bn;
    // multiply uses an*bn, with ad*bd standing in the second and third slots.
    always_comb
    begin
        mul_x = ad_s;
        mul_y = bd_s;
        case (state_reg)
            ST_MUL0:
            begin
                mul_x = an_reg;
                mul_y = (func_reg == FN_MUL) ? bn_reg : bd_s;
            end
            ST_MUL1:
            begin
                mul_x = (func_reg == FN_MUL) ? ad_s : bn_reg;
                mul_y = (func_reg == FN_MUL) ? bd_s : ad_s;
            end
            default:
            begin
                mul_x = ad_s;
                mul_y = bd_s;
            end
        endcase
    end

    rar_mul u_mul (
        .clk   (clk),
        .x     (mul_x),
        .y     (mul_y),
        .p_reg (mul_p)
    );

    // Numerator and denominator before reduction. For divide, a negative
    // denominator moves its sign onto the numerator.
    always_comb
    begin
        n_next = pa_reg;
        d_next = pc_reg;
        unique case (func_reg)
            FN_ADD:
            begin
                n_next = pa_reg + pb_reg;
                d_next = pc_reg;
            end
            FN_SUB:
            begin
                n_next = pa_reg - pb_reg;
                d_next = pc_reg;
            end
            FN_MUL:
            begin
                n_next = pa_reg;
                d_next = pc_reg;
            end
            FN_DIV:
            begin
                n_next = pb_reg[PROD_W-1] ? -pa_reg : pa_reg;
                d_next = pb_reg[PROD_W-1] ? -pb_reg : pb_reg;
            end
            default:
            begin
                n_next = pa_reg;
                d_next = pc_reg;
            end
        endcase
    end

    assign n_abs = n_reg[PROD_W-1] ? -n_reg : n_reg;

    assign rd_req.start = rd_start;
    assign rd_req.mag   = n_abs[MAG_W-1:0];
    assign rd_req.den   = d_reg[DEN_W-1:0];

    rar_reduce u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rd_req),
        .rsp   (rd_rsp)
    );

    // Main sequencer.
    always_comb
    begin
        state_next = state_reg;
        rd_start   = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:   if (in_fire) state_next = ST_MUL0;
            ST_MUL0:   state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_MUL3;
            ST_MUL3:   state_next = ST_SIGN;
            ST_SIGN:   state_next = ST_ABS;
            ST_ABS:
            begin
                rd_start   = 1'b1;
                state_next = ST_REDUCE;
            end
            ST_REDUCE: if (rd_rsp.done) state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Operand capture. Numerator fields are taken as raw bit patterns and the low
    // WIDTH bits are read as two's complement; denominators keep their low WIDTH-1 bits.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg <= func_t'(func);
            an_reg   <= $signed(WIDTH'($unsigned(a_num)));
            bn_reg   <= $signed(WIDTH'($unsigned(b_num)));
            ad_reg   <= (WIDTH - 1)'(a_den);
            bd_reg   <= (WIDTH - 1)'(b_den);
        end
        if (state_reg == ST_MUL1)
            pa_reg <= mul_p;
        if (state_reg == ST_MUL2)
            pb_reg <= mul_p;
        if (state_reg == ST_MUL3)
            pc_reg <= mul_p;
        if (state_reg == ST_SIGN)
        begin
            n_reg <= n_next;
            d_reg <= d_next;
        end
        if (state_reg == ST_ABS)
        begin
            neg_reg <= n_reg[PROD_W-1];
            bad_reg <= (d_reg[PROD_W-1] || d_reg == '0) && (n_reg != '0);
        end
    end

    // Sign goes back onto the reduced magnitude.
    assign num_signed = neg_reg ? -$signed({1'b0, rd_rsp.mag}) : $signed({1'b0, rd_rsp.mag});

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            res_num_reg <= RES_NUM_W'(num_signed);
            res_den_reg <= RES_DEN_W'(rd_rsp.den);
            bad_den_reg <= bad_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign bad_den   = bad_den_reg;

    `RAR_ASSERT_NXT(a_accept_blocks, clk, rst_n, in_fire, in_stall)
    `RAR_ASSERT_IMP(a_done_in_reduce, clk, rst_n, rd_rsp.done, state_reg == ST_REDUCE)
    `RAR_ASSERT_NXT(a_result_loaded, clk, rst_n, state_reg == ST_OUT && out_free, out_valid)
    `RAR_ASSERT_IMP(a_bad_zero_den, clk, rst_n, out_valid && bad_den, res_den == '0)

endmodule
